@@ hdl/gcf_pkg.sv @@
package gcf_pkg;

  localparam int DEF_QUEUE_DEPTH = 256;
  localparam int PIPE_DEPTH      = 4;
  localparam int PIPE_AW         = $clog2(PIPE_DEPTH);
  localparam int PIPE_CW         = $clog2(PIPE_DEPTH + 1);

  localparam logic [1:0] KIND_PACKED = 2'd0;
  localparam logic [1:0] KIND_DIRECT = 2'd1;
  localparam logic [1:0] KIND_POP    = 2'd2;

  localparam logic [1:0] IRQ_BELOW_HALF = 2'd1;
  localparam logic [1:0] IRQ_EMPTY      = 2'd2;

  typedef struct packed {
    logic [7:0]  cmd;
    logic [31:0] arg;
  } entry_t;

  typedef struct packed {
    logic               push_en;
    logic [PIPE_AW-1:0] push_slot;
    logic               mv0_en;
    logic [PIPE_AW-1:0] mv0_slot;
    logic               mv1_en;
    logic [PIPE_AW-1:0] mv1_slot;
    logic [PIPE_AW-1:0] rd_slot;
  } pipe_ctl_t;

  typedef struct packed {
    logic               entry_valid;
    logic [7:0]         entry_command;
    logic [31:0]        entry_param;
    logic [PIPE_CW-1:0] pipe_level;
    logic               queue_full;
    logic               queue_below_half;
    logic               queue_empty;
    logic               irq_request;
    logic               overflow;
    logic               underflow;
  } result_t;

  // parameter words each command takes
  function automatic logic [5:0] arg_count(input logic [7:0] cmd);
    logic [5:0] n;
    case (cmd)
      8'h10, 8'h12, 8'h13, 8'h14: n = 6'd1;
      8'h16, 8'h18:               n = 6'd16;
      8'h17, 8'h19:               n = 6'd12;
      8'h1A:                      n = 6'd9;
      8'h1B, 8'h1C:               n = 6'd3;
      8'h20, 8'h21, 8'h22, 8'h24,
      8'h25, 8'h26, 8'h27, 8'h28,
      8'h29, 8'h2A, 8'h2B:        n = 6'd1;
      8'h23:                      n = 6'd2;
      8'h30, 8'h31, 8'h32, 8'h33: n = 6'd1;
      8'h34:                      n = 6'd32;
      8'h40, 8'h50, 8'h60:        n = 6'd1;
      8'h70:                      n = 6'd3;
      8'h71:                      n = 6'd2;
      8'h72:                      n = 6'd1;
      default:                    n = 6'd0;
    endcase
    return n;
  endfunction

endpackage

@@ hdl/gcf_if.sv @@
interface gcf_in_if import gcf_pkg::*;;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] data;
  logic [9:0]  port_offset;

  modport source (output valid, kind, data, port_offset, input ready);
  modport sink   (input valid, kind, data, port_offset, output ready);
endinterface

interface gcf_out_if import gcf_pkg::*; #(
  parameter int QLW = $clog2(DEF_QUEUE_DEPTH + 1)
);
  logic               valid;
  logic               ready;
  logic               entry_valid;
  logic [7:0]         entry_command;
  logic [31:0]        entry_param;
  logic [QLW-1:0]     queue_level;
  logic [PIPE_CW-1:0] pipe_level;
  logic               queue_full;
  logic               queue_below_half;
  logic               queue_empty;
  logic               irq_request;
  logic               overflow;
  logic               underflow;

  modport source (output valid, entry_valid, entry_command, entry_param, queue_level,
                  pipe_level, queue_full, queue_below_half, queue_empty, irq_request,
                  overflow, underflow, input ready);
  modport sink   (input valid, entry_valid, entry_command, entry_param, queue_level,
                  pipe_level, queue_full, queue_below_half, queue_empty, irq_request,
                  overflow, underflow, output ready);
endinterface

@@ hdl/geometry_command_fifo_unit.sv @@
// Channel  Dir  Handshake     Payload
// in_ch    in   valid/ready   kind, data, port_offset
// out_ch   out  valid/ready   entry, queue/pipe levels, status flags
// cfg      in   cfg_we        cfg_wdata = irq_mode
//
// One transaction per cycle while in_ch.ready is high; its result is registered and shows in the next cycle.
// Queue refill reads are registered in the queue RAM and written into the pipe in
// the following cycle, with a bypass to the pipe head read.
// Synchronous active-low reset clears all pointers and counts; no clearing pass.
// in_ch.ready drops only while a result is held and out_ch.ready is low.
module geometry_command_fifo_unit import gcf_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  gcf_in_if.sink     in_ch,
  gcf_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata
);

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  logic [1:0]         irq_mode_r;
  logic [31:0]        packed_r, packed_nxt;
  logic [5:0]         pwrites_r, pwrites_nxt;
  logic [PIPE_AW-1:0] phead_r, phead_nxt;
  logic [PIPE_CW-1:0] pcount_r, pcount_nxt;
  logic [QAW-1:0]     qhead_r, qhead_nxt;
  logic [QAW-1:0]     qtail_r, qtail_nxt;
  logic [QCW-1:0]     qcount_r, qcount_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            res_r, res_nxt;
  logic [QCW-1:0]     qlevel_r;

  logic               acc;
  logic               is_pop;
  logic               do_add;
  logic               to_pipe;
  logic               to_queue;
  logic               pop_ok;
  logic               refill;
  logic [PIPE_CW-1:0] pc_after;
  logic [5:0]         pw_inc;
  logic [QAW-1:0]     qhead_p1;
  logic [QAW-1:0]     qhead_p2;
  entry_t             new_entry;
  entry_t             head_entry;
  entry_t             mv0_data;
  entry_t             mv1_data;
  pipe_ctl_t          pctl;

  function automatic logic [QAW-1:0] qinc(input logic [QAW-1:0] p);
    return (p == QAW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign is_pop      = in_ch.kind == KIND_POP;
  assign qhead_p1    = qinc(qhead_r);
  assign qhead_p2    = qinc(qhead_p1);
  assign pw_inc      = pwrites_r + 6'd1;
  assign pc_after    = pcount_r - 1'b1;

  always_comb begin
    new_entry.arg = in_ch.data;
    new_entry.cmd = (in_ch.kind == KIND_PACKED) ? packed_r[7:0] : in_ch.port_offset[9:2];
    do_add   = acc && ((in_ch.kind == KIND_PACKED && packed_r != '0) ||
                       in_ch.kind == KIND_DIRECT);
    to_pipe  = qcount_r == '0 && pcount_r < PIPE_CW'(PIPE_DEPTH);
    to_queue = !to_pipe && qcount_r < QCW'(QUEUE_DEPTH);
    pop_ok   = acc && is_pop && pcount_r != '0;
    refill   = pop_ok && pc_after < PIPE_CW'(3);

    packed_nxt  = packed_r;
    pwrites_nxt = pwrites_r;
    phead_nxt   = phead_r;
    pcount_nxt  = pcount_r;
    qhead_nxt   = qhead_r;
    qtail_nxt   = qtail_r;
    qcount_nxt  = qcount_r;

    pctl.push_en   = do_add && to_pipe;
    pctl.push_slot = phead_r + pcount_r[PIPE_AW-1:0];
    pctl.mv0_en    = refill && qcount_r >= QCW'(1);
    pctl.mv0_slot  = phead_r + pcount_r[PIPE_AW-1:0];
    pctl.mv1_en    = refill && qcount_r >= QCW'(2);
    pctl.mv1_slot  = phead_r + pcount_r[PIPE_AW-1:0] + 1'b1;
    pctl.rd_slot   = phead_r;

    if (acc && in_ch.kind == KIND_PACKED) begin
      if (packed_r == '0) begin
        packed_nxt = in_ch.data;
      end else if (pw_inc >= arg_count(packed_r[7:0])) begin
        packed_nxt  = packed_r >> 8;
        pwrites_nxt = '0;
      end else begin
        pwrites_nxt = pw_inc;
      end
    end

    if (do_add) begin
      if (to_pipe) begin
        pcount_nxt = pcount_r + 1'b1;
      end else if (to_queue) begin
        qtail_nxt  = qinc(qtail_r);
        qcount_nxt = qcount_r + 1'b1;
      end
    end

    if (pop_ok) begin
      phead_nxt  = phead_r + 1'b1;
      pcount_nxt = pc_after;
      if (pctl.mv1_en) begin
        qhead_nxt  = qhead_p2;
        qcount_nxt = qcount_r - QCW'(2);
        pcount_nxt = pc_after + PIPE_CW'(2);
      end else if (pctl.mv0_en) begin
        qhead_nxt  = qhead_p1;
        qcount_nxt = qcount_r - QCW'(1);
        pcount_nxt = pc_after + PIPE_CW'(1);
      end
    end

    res_nxt.entry_valid      = pop_ok;
    res_nxt.entry_command    = pop_ok ? head_entry.cmd : 8'd0;
    res_nxt.entry_param      = pop_ok ? head_entry.arg : 32'd0;
    res_nxt.pipe_level       = pcount_nxt;
    res_nxt.queue_full       = qcount_nxt == QCW'(QUEUE_DEPTH);
    res_nxt.queue_below_half = qcount_nxt < QCW'(QUEUE_DEPTH / 2);
    res_nxt.queue_empty      = qcount_nxt == '0;
    res_nxt.irq_request      = refill &&
                               ((irq_mode_r == IRQ_BELOW_HALF &&
                                 qcount_nxt < QCW'(QUEUE_DEPTH / 2)) ||
                                (irq_mode_r == IRQ_EMPTY && qcount_nxt == '0));
    res_nxt.overflow         = do_add && !to_pipe && !to_queue;
    res_nxt.underflow        = acc && is_pop && pcount_r == '0;

    out_valid_nxt = acc ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  gcf_qmem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (QAW)
  ) u_qmem (
    .clk    (clk),
    .we     (do_add && to_queue),
    .waddr  (qtail_r),
    .wdata  (new_entry),
    .raddr0 (qhead_r),
    .raddr1 (qhead_p1),
    .rdata0 (mv0_data),
    .rdata1 (mv1_data)
  );

  gcf_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (pctl),
    .push_data (new_entry),
    .mv0_data  (mv0_data),
    .mv1_data  (mv1_data),
    .head_data (head_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irq_mode_r  <= '0;
      packed_r    <= '0;
      pwrites_r   <= '0;
      phead_r     <= '0;
      pcount_r    <= '0;
      qhead_r     <= '0;
      qtail_r     <= '0;
      qcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        irq_mode_r <= cfg_wdata;
      end
      packed_r    <= packed_nxt;
      pwrites_r   <= pwrites_nxt;
      phead_r     <= phead_nxt;
      pcount_r    <= pcount_nxt;
      qhead_r     <= qhead_nxt;
      qtail_r     <= qtail_nxt;
      qcount_r    <= qcount_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (acc) begin
      res_r    <= res_nxt;
      qlevel_r <= qcount_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.entry_valid      = res_r.entry_valid;
  assign out_ch.entry_command    = res_r.entry_command;
  assign out_ch.entry_param      = res_r.entry_param;
  assign out_ch.queue_level      = qlevel_r;
  assign out_ch.pipe_level       = res_r.pipe_level;
  assign out_ch.queue_full       = res_r.queue_full;
  assign out_ch.queue_below_half = res_r.queue_below_half;
  assign out_ch.queue_empty      = res_r.queue_empty;
  assign out_ch.irq_request      = res_r.irq_request;
  assign out_ch.overflow         = res_r.overflow;
  assign out_ch.underflow        = res_r.underflow;

  // queue only fills once the pipe is topped up
  a_queue_behind_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    qcount_r != '0 |-> pcount_r >= PIPE_CW'(3))
    else $error("queue holds entries while pipe is low");

  a_pipe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pcount_r <= PIPE_CW'(PIPE_DEPTH) && qcount_r <= QCW'(QUEUE_DEPTH))
    else $error("level out of range");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    acc && is_pop && pcount_r == '0 |=> out_valid_r && res_r.underflow && !res_r.entry_valid)
    else $error("pop on empty pipe not flagged");

  a_refill_pending: assert property (@(posedge clk) disable iff (!rst_n)
    pctl.mv1_en |-> pctl.mv0_en)
    else $error("second refill without first");

endmodule

@@ hdl/gcf_qmem.sv @@
module gcf_qmem import gcf_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH,
  parameter int AW    = $clog2(DEF_QUEUE_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output entry_t        rdata0,
  output entry_t        rdata1
);

  entry_t mem [DEPTH];
  entry_t rd0_r;
  entry_t rd1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd0_r <= mem[raddr0];
    rd1_r <= mem[raddr1];
  end

  assign rdata0 = rd0_r;
  assign rdata1 = rd1_r;

endmodule

@@ hdl/gcf_pipe.sv @@
module gcf_pipe import gcf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  pipe_ctl_t ctl,
  input  entry_t    push_data,
  input  entry_t    mv0_data,
  input  entry_t    mv1_data,
  output entry_t    head_data
);

  entry_t             store_r [PIPE_DEPTH];
  logic               pend0_r;
  logic               pend1_r;
  logic [PIPE_AW-1:0] pend0_slot_r;
  logic [PIPE_AW-1:0] pend1_slot_r;

  // refill data lands in the cycle after the queue read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend0_r <= 1'b0;
      pend1_r <= 1'b0;
    end else begin
      pend0_r <= ctl.mv0_en;
      pend1_r <= ctl.mv1_en;
    end
    pend0_slot_r <= ctl.mv0_slot;
    pend1_slot_r <= ctl.mv1_slot;
    if (pend0_r) begin
      store_r[pend0_slot_r] <= mv0_data;
    end
    if (pend1_r) begin
      store_r[pend1_slot_r] <= mv1_data;
    end
    if (ctl.push_en) begin
      store_r[ctl.push_slot] <= push_data;
    end
  end

  always_comb begin
    if (pend0_r && pend0_slot_r == ctl.rd_slot) begin
      head_data = mv0_data;
    end else if (pend1_r && pend1_slot_r == ctl.rd_slot) begin
      head_data = mv1_data;
    end else begin
      head_data = store_r[ctl.rd_slot];
    end
  end

endmodule
